FILE: rtl/core/rff_pkg.sv
// Types, widths and payload structs shared by the radial falloff force pipeline.
`timescale 1ns / 1ps
package rff_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int ReachW = 23;
  localparam int StrW   = 16;
  localparam int SqW    = 2 * DiffW;
  localparam int SumW   = SqW + 1;
  localparam int LenW   = ReachW;
  localparam int RadW   = 2 * LenW;
  localparam int SdW    = StrW + ReachW;
  localparam int NumW   = LenW + SdW;
  localparam int DenW   = LenW + ReachW;
  localparam int QuoW   = StrW;

  typedef struct packed {
    logic                     func;
    logic signed [CoordW-1:0] particle_x;
    logic signed [CoordW-1:0] particle_y;
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic        [ReachW-1:0] reach;
    logic signed [StrW-1:0]   strength;
  } rff_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] push_x;
    logic signed [CoordW-1:0] push_y;
    logic                     in_reach;
  } rff_out_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    logic              func;
    logic              neg_dx;
    logic              neg_dy;
    logic              neg_s;
    logic              in_reach;
    logic [LenW-1:0]   mag_x;
    logic [LenW-1:0]   mag_y;
    logic [StrW-1:0]   mag_s;
    logic [ReachW-1:0] reach;
  } rff_side_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic in_reach;
    logic neg_x;
    logic neg_y;
    logic zero;
  } rff_dside_t;

endpackage

FILE: rtl/core/rff_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rff_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rff_pkg::RadW-1:0]     rad_i,
  input  rff_pkg::rff_side_t           side_i,
  output logic                         valid_o,
  output logic [rff_pkg::LenW-1:0]     root_o,
  output rff_pkg::rff_side_t           side_o
);

  localparam int Steps = rff_pkg::LenW;
  localparam int RadW  = rff_pkg::RadW;
  localparam int ResW  = RadW + 1;

  logic [RadW-1:0]    v_q   [Steps];
  logic [ResW-1:0]    res_q [Steps];
  rff_pkg::rff_side_t side_q [Steps];
  logic [Steps-1:0]   valid_q;

  logic [RadW-1:0]    v_d   [Steps];
  logic [ResW-1:0]    res_d [Steps];

  // Each stage tests one bit pair of the radicand against the partial root plus a fixed trial bit.
  always_comb begin
    logic [RadW-1:0] v_in;
    logic [ResW-1:0] res_in;
    logic [ResW-1:0] bit_val;
    logic [ResW-1:0] trial;
    for (int i = 0; i < Steps; i++) begin
      v_in    = (i == 0) ? rad_i : v_q[(i == 0) ? 0 : i - 1];
      res_in  = (i == 0) ? '0 : res_q[(i == 0) ? 0 : i - 1];
      bit_val = ResW'(1) << (2 * (Steps - 1 - i));
      trial   = res_in + bit_val;
      if ({1'b0, v_in} >= trial) begin
        v_d[i]   = v_in - trial[RadW-1:0];
        res_d[i] = (res_in >> 1) + bit_val;
      end else begin
        v_d[i]   = v_in;
        res_d[i] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < Steps; i++) begin
        v_q[i]    <= v_d[i];
        res_q[i]  <= res_d[i];
        side_q[i] <= (i == 0) ? side_i : side_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = res_q[Steps-1][rff_pkg::LenW-1:0];
  assign side_o  = side_q[Steps-1];

endmodule

FILE: rtl/core/rff_div.sv
// Pipelined restoring divider for both force components, one quotient bit per stage.
`timescale 1ns / 1ps
module rff_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rff_pkg::NumW-1:0]     num_x_i,
  input  logic [rff_pkg::NumW-1:0]     num_y_i,
  input  logic [rff_pkg::DenW-1:0]     den_i,
  input  rff_pkg::rff_dside_t          side_i,
  output logic                         valid_o,
  output logic [rff_pkg::QuoW-1:0]     quo_x_o,
  output logic [rff_pkg::QuoW-1:0]     quo_y_o,
  output rff_pkg::rff_dside_t          side_o
);

  localparam int Steps = rff_pkg::QuoW;
  localparam int NumW  = rff_pkg::NumW;
  localparam int DenW  = rff_pkg::DenW;

  logic [NumW-1:0]     rx_q [Steps];
  logic [NumW-1:0]     ry_q [Steps];
  logic [Steps-1:0]    qx_q [Steps];
  logic [Steps-1:0]    qy_q [Steps];
  logic [DenW-1:0]     den_q [Steps];
  rff_pkg::rff_dside_t side_q [Steps];
  logic [Steps-1:0]    valid_q;

  logic [NumW-1:0]  rx_d [Steps];
  logic [NumW-1:0]  ry_d [Steps];
  logic [Steps-1:0] qx_d [Steps];
  logic [Steps-1:0] qy_d [Steps];
  logic [DenW-1:0]  den_d [Steps];

  // The quotient is known to stay below 2^QuoW, so the steps start at the top bit.
  always_comb begin
    logic [NumW-1:0]  rx_in;
    logic [NumW-1:0]  ry_in;
    logic [Steps-1:0] qx_in;
    logic [Steps-1:0] qy_in;
    logic [NumW-1:0]  sh;
    for (int k = 0; k < Steps; k++) begin
      rx_in    = (k == 0) ? num_x_i : rx_q[(k == 0) ? 0 : k - 1];
      ry_in    = (k == 0) ? num_y_i : ry_q[(k == 0) ? 0 : k - 1];
      qx_in    = (k == 0) ? '0 : qx_q[(k == 0) ? 0 : k - 1];
      qy_in    = (k == 0) ? '0 : qy_q[(k == 0) ? 0 : k - 1];
      den_d[k] = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k - 1];
      sh       = NumW'(den_d[k]) << (Steps - 1 - k);
      if (rx_in >= sh) begin
        rx_d[k] = rx_in - sh;
        qx_d[k] = {qx_in[Steps-2:0], 1'b1};
      end else begin
        rx_d[k] = rx_in;
        qx_d[k] = {qx_in[Steps-2:0], 1'b0};
      end
      if (ry_in >= sh) begin
        ry_d[k] = ry_in - sh;
        qy_d[k] = {qy_in[Steps-2:0], 1'b1};
      end else begin
        ry_d[k] = ry_in;
        qy_d[k] = {qy_in[Steps-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Steps; k++) begin
        rx_q[k]   <= rx_d[k];
        ry_q[k]   <= ry_d[k];
        qx_q[k]   <= qx_d[k];
        qy_q[k]   <= qy_d[k];
        den_q[k]  <= den_d[k];
        side_q[k] <= (k == 0) ? side_i : side_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign quo_x_o = qx_q[Steps-1];
  assign quo_y_o = qy_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

FILE: rtl/core/radial_falloff_force_core.sv
// Top level of the radial falloff force pipeline.
// Throughput: one beat per cycle while the output is not stalled; the 23-stage square
// root and the 16-stage divider are fully pipelined, so neither limits the rate.
// The whole pipeline advances together and holds while a result waits.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module radial_falloff_force_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rff_pkg::rff_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rff_pkg::rff_out_t out_data_o
);

  localparam int DiffW  = rff_pkg::DiffW;
  localparam int CoordW = rff_pkg::CoordW;
  localparam int StrW   = rff_pkg::StrW;
  localparam int LenW   = rff_pkg::LenW;

  // Every stage moves when the output register is empty or being drained.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: difference vector.
  logic                     s1_valid_q;
  logic signed [DiffW-1:0]  s1_dx_q, s1_dy_q;
  logic                     s1_func_q;
  logic [rff_pkg::ReachW-1:0] s1_reach_q;
  logic signed [StrW-1:0]   s1_str_q;

  // Stage 2: magnitudes and signs.
  logic                     s2_valid_q;
  logic [DiffW-1:0]         s2_mx_q, s2_my_q;
  logic [StrW-1:0]          s2_ms_q;
  logic                     s2_nx_q, s2_ny_q, s2_ns_q, s2_func_q;
  logic [rff_pkg::ReachW-1:0] s2_reach_q;

  // Stage 3: squares.
  logic                     s3_valid_q;
  logic [rff_pkg::SqW-1:0]  s3_sqx_q, s3_sqy_q;
  logic [rff_pkg::RadW-1:0] s3_r2_q;
  rff_pkg::rff_side_t       s3_side_q;

  // Stage 4: squared length and reach test.
  logic                     s4_valid_q;
  logic [rff_pkg::RadW-1:0] s4_rad_q;
  rff_pkg::rff_side_t       s4_side_q;
  rff_pkg::rff_side_t       s4_side_d;

  logic [rff_pkg::SumW-1:0] len2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  assign len2 = rff_pkg::SumW'(s3_sqx_q) + rff_pkg::SumW'(s3_sqy_q);

  // The reach test joins the side data on its way into stage 4.
  always_comb begin
    s4_side_d          = s3_side_q;
    s4_side_d.in_reach = (len2 <= rff_pkg::SumW'(s3_r2_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q    <= DiffW'(in_data_i.particle_x) - DiffW'(in_data_i.centre_x);
      s1_dy_q    <= DiffW'(in_data_i.particle_y) - DiffW'(in_data_i.centre_y);
      s1_func_q  <= in_data_i.func;
      s1_reach_q <= in_data_i.reach;
      s1_str_q   <= in_data_i.strength;

      s2_mx_q    <= s1_dx_q[DiffW-1] ? DiffW'(-s1_dx_q) : DiffW'(s1_dx_q);
      s2_my_q    <= s1_dy_q[DiffW-1] ? DiffW'(-s1_dy_q) : DiffW'(s1_dy_q);
      s2_ms_q    <= s1_str_q[StrW-1] ? StrW'(-s1_str_q) : StrW'(s1_str_q);
      s2_nx_q    <= s1_dx_q[DiffW-1];
      s2_ny_q    <= s1_dy_q[DiffW-1];
      s2_ns_q    <= s1_str_q[StrW-1];
      s2_func_q  <= s1_func_q;
      s2_reach_q <= s1_reach_q;

      s3_sqx_q           <= s2_mx_q * s2_mx_q;
      s3_sqy_q           <= s2_my_q * s2_my_q;
      s3_r2_q            <= s2_reach_q * s2_reach_q;
      s3_side_q.func     <= s2_func_q;
      s3_side_q.neg_dx   <= s2_nx_q;
      s3_side_q.neg_dy   <= s2_ny_q;
      s3_side_q.neg_s    <= s2_ns_q;
      s3_side_q.in_reach <= 1'b0;
      // Within reach both components are no larger than the reach, so the low bits suffice.
      s3_side_q.mag_x    <= s2_mx_q[LenW-1:0];
      s3_side_q.mag_y    <= s2_my_q[LenW-1:0];
      s3_side_q.mag_s    <= s2_ms_q;
      s3_side_q.reach    <= s2_reach_q;

      // Out of reach the root is never used, so a truncated radicand is fine.
      s4_rad_q           <= len2[rff_pkg::RadW-1:0];
      s4_side_q          <= s4_side_d;
    end
  end

  // Length of the difference vector.
  logic                 sq_valid;
  logic [LenW-1:0]      sq_root;
  rff_pkg::rff_side_t   sq_side;

  rff_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_valid_q),
    .rad_i   (s4_rad_q),
    .side_i  (s4_side_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage M1: strength times remaining reach, and the denominator.
  logic                      m1_valid_q;
  logic [rff_pkg::SdW-1:0]   m1_sd_q;
  logic [rff_pkg::DenW-1:0]  m1_den_q;
  logic [LenW-1:0]           m1_mx_q, m1_my_q;
  rff_pkg::rff_dside_t       m1_side_q;

  // Stage M2: full numerators.
  logic                      m2_valid_q;
  logic [rff_pkg::NumW-1:0]  m2_numx_q, m2_numy_q;
  logic [rff_pkg::DenW-1:0]  m2_den_q;
  rff_pkg::rff_dside_t       m2_side_q;

  logic [rff_pkg::ReachW-1:0] rem_reach;
  assign rem_reach = sq_side.reach - sq_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= sq_valid;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_sd_q            <= sq_side.mag_s * rem_reach;
      m1_den_q           <= sq_root * sq_side.reach;
      m1_mx_q            <= sq_side.mag_x;
      m1_my_q            <= sq_side.mag_y;
      m1_side_q.in_reach <= sq_side.in_reach;
      m1_side_q.neg_x    <= sq_side.neg_dx ^ sq_side.neg_s ^ sq_side.func;
      m1_side_q.neg_y    <= sq_side.neg_dy ^ sq_side.neg_s ^ sq_side.func;
      // A zero length would divide by zero; the force is zero there.
      m1_side_q.zero     <= (sq_root == '0);

      m2_numx_q <= m1_mx_q * m1_sd_q;
      m2_numy_q <= m1_my_q * m1_sd_q;
      m2_den_q  <= m1_den_q;
      m2_side_q <= m1_side_q;
    end
  end

  logic                      dv_valid;
  logic [rff_pkg::QuoW-1:0]  dv_qx, dv_qy;
  rff_pkg::rff_dside_t       dv_side;

  rff_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_valid_q),
    .num_x_i (m2_numx_q),
    .num_y_i (m2_numy_q),
    .den_i   (m2_den_q),
    .side_i  (m2_side_q),
    .valid_o (dv_valid),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy),
    .side_o  (dv_side)
  );

  // Output register: sign the quotients. Their magnitude never exceeds
  // |strength|, so the 24-bit result cannot overflow.
  logic              out_valid_q;
  rff_pkg::rff_out_t out_data_q;
  logic [CoordW-1:0] qx_ext, qy_ext;
  logic              force_zero;

  assign qx_ext     = CoordW'(dv_qx);
  assign qy_ext     = CoordW'(dv_qy);
  assign force_zero = !dv_side.in_reach || dv_side.zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.in_reach <= dv_side.in_reach;
      if (force_zero) begin
        out_data_q.push_x <= '0;
        out_data_q.push_y <= '0;
      end else begin
        out_data_q.push_x <= dv_side.neg_x ? -qx_ext : qx_ext;
        out_data_q.push_y <= dv_side.neg_y ? -qy_ext : qy_ext;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An out-of-reach result carries no force.
  a_no_force_out_of_reach : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_reach |-> out_data_o.push_x == '0 && out_data_o.push_y == '0)
    else $error("force given outside reach");

  // The force magnitude never exceeds the largest strength magnitude.
  a_force_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.push_x <= 24'sd32768 && out_data_o.push_x >= -24'sd32768 &&
                    out_data_o.push_y <= 24'sd32768 && out_data_o.push_y >= -24'sd32768)
    else $error("force magnitude out of bounds");

  // A result that is stalled stays put until taken.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o) && !$past(in_ready_o))
    else $error("stalled result changed");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the radial falloff force pipeline.
`timescale 1ns / 1ps
module tb;

  localparam int NumRandom  = 1550;
  localparam int IdlePct    = 31;
  localparam int QuietFirst = 600;
  localparam int QuietLast  = 900;
  localparam int DrainWait  = 60;
  localparam int StuckLimit = 3000;
  localparam longint FrcMax = 64'sd8388607;
  localparam longint CrdMax = 64'sd8388607;
  localparam longint CrdMin = -64'sd8388608;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  rff_pkg::rff_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rff_pkg::rff_out_t out_data_o;
  logic              quiet = 1'b0;
  int                stuck_cycles = 0;

  always #1 clk_i = ~clk_i;

  radial_falloff_force_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Holds the forces still owed by the block and checks each result beat
  // against the oldest one.
  class force_board;
    rff_pkg::rff_out_t owed[$];
    int                errors = 0;

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    // One force component: |d|*|s|*(reach-len)/(len*reach), truncated,
    // then signed and saturated to 24 bits.
    function logic [rff_pkg::CoordW-1:0] axis_force(longint d, longint s, bit attract,
                                                    longint unsigned len,
                                                    longint unsigned rch);
      longint unsigned q;
      longint          r;
      bit              neg;
      if (d == 0 || s == 0 || len == 0 || rch == 0) return '0;
      q = ((d < 0 ? -d : d) * (s < 0 ? -s : s) * (rch - len)) / (len * rch);
      if (q > FrcMax + 1) q = FrcMax + 1;
      neg = ((d < 0) != (s < 0)) != attract;
      if (neg) r = -longint'(q);
      else r = (q > FrcMax) ? FrcMax : longint'(q);
      return r[rff_pkg::CoordW-1:0];
    endfunction

    function rff_pkg::rff_out_t predict_force(rff_pkg::rff_in_t p);
      rff_pkg::rff_out_t o;
      longint            dx, dy, s;
      longint unsigned   rch, len2, len;
      dx   = longint'(p.particle_x) - longint'(p.centre_x);
      dy   = longint'(p.particle_y) - longint'(p.centre_y);
      s    = longint'(p.strength);
      rch  = p.reach;
      len2 = dx * dx + dy * dy;
      o    = '0;
      if (len2 > rch * rch) return o;
      len = int_root(len2);
      if (len > rch) len = rch;
      o.push_x   = axis_force(dx, s, p.func, len, rch);
      o.push_y   = axis_force(dy, s, p.func, len, rch);
      o.in_reach = 1'b1;
      return o;
    endfunction

    function void note_input(rff_pkg::rff_in_t p);
      owed.push_back(predict_force(p));
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(rff_pkg::rff_out_t got);
      rff_pkg::rff_out_t want;
      if (owed.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = owed.pop_front();
      if (got.push_x !== want.push_x)
        report($sformatf("push_x got %0d want %0d", got.push_x, want.push_x));
      if (got.push_y !== want.push_y)
        report($sformatf("push_y got %0d want %0d", got.push_y, want.push_y));
      if (got.in_reach !== want.in_reach)
        report($sformatf("in_reach got %0b want %0b", got.in_reach, want.in_reach));
    endtask
  endclass

  force_board board = new();

  // Monitors sample pre-edge values, so they see exactly what the block saw.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_input(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // The receiver stalls at random, except through the quiet stretch.
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= IdlePct);
  end

  // Watchdog: counts cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Presents one beat and holds it until the block takes it. Valid only drops
  // when the sender decides to idle before the next beat.
  task send_beat(rff_pkg::rff_in_t p);
    if (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < IdlePct) @(posedge clk_i);
    end
    in_data_i  <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task send_fields(bit f, longint px, longint py, longint cx, longint cy,
                   longint rch, longint s);
    rff_pkg::rff_in_t p;
    p.func       = f;
    p.particle_x = px[rff_pkg::CoordW-1:0];
    p.particle_y = py[rff_pkg::CoordW-1:0];
    p.centre_x   = cx[rff_pkg::CoordW-1:0];
    p.centre_y   = cy[rff_pkg::CoordW-1:0];
    p.reach      = rch[rff_pkg::ReachW-1:0];
    p.strength   = s[rff_pkg::StrW-1:0];
    send_beat(p);
  endtask

  // Centre placed so that it always lies within reach of the particle.
  function longint near_coord(longint pos, longint rch);
    longint off, c;
    off = longint'($urandom_range(0, 32'(2 * rch))) - rch;
    off = (off * 7) / 10;
    c = pos - off;
    if (c > CrdMax || c < CrdMin) c = pos + off;
    return c;
  endfunction

  initial begin
    rff_pkg::rff_in_t p;
    longint           rch, px, py;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero length, out of reach, right on the edge, field extremes.
    send_fields(0, 100, 100, 100, 100, 256, 256);
    send_fields(1, -5, 7, -5, 7, 1, -32768);
    send_fields(0, 0, 0, 1000, 0, 500, 256);
    send_fields(0, 300, 400, 0, 0, 500, 1000);
    send_fields(1, 300, 399, 0, 0, 500, 1000);
    send_fields(0, CrdMax, CrdMin, CrdMin, CrdMax, 8388607, 32767);
    send_fields(0, CrdMax, 0, CrdMax - 1, 0, 1, 32767);
    send_fields(0, 4000000, 0, -4000000, 0, 8388607, -32768);
    send_fields(1, 4000000, 0, -4000000, 0, 8388607, -32768);
    send_fields(0, 1, 0, 0, 0, 8388607, 32767);
    send_fields(1, 0, -1, 0, 0, 8388607, 32767);
    send_fields(0, 0, CrdMin, 0, CrdMin + 5000000, 8388607, -32768);
    send_fields(1, -20, 30, 10, -10, 100, 0);
    send_fields(0, -20, 30, 10, -10, 100, 1);
    send_fields(1, 0, 0, CrdMax, CrdMax, 8388607, -1);
    send_fields(0, 1000, -1000, -1000, 1000, 3000, 32767);

    for (int i = 0; i < NumRandom; i++) begin
      quiet = (i >= QuietFirst && i < QuietLast);
      if ($urandom_range(0, 9) < 2) begin
        // Noise: every field random, with a zero reach raised to one.
        p = rff_pkg::rff_in_t'({$urandom, $urandom, $urandom, $urandom, 8'($urandom)});
        if (p.reach == 0) p.reach = 1;
        send_beat(p);
      end else begin
        rch = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8388607)
                                          : $urandom_range(1, 4096);
        px = longint'($urandom_range(0, 16777215)) - 8388608;
        py = longint'($urandom_range(0, 16777215)) - 8388608;
        send_fields(1'($urandom_range(0, 1)), px, py, near_coord(px, rch),
                    near_coord(py, rch), rch,
                    longint'($urandom_range(0, 65535)) - 32768);
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
